>>> hw/rtl/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types, codes and helpers for the SPI EEPROM access sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

   localparam int ADDRESS_BITS_DEFAULT = 17;
   localparam int PAGE_BYTES_DEFAULT   = 256;
   localparam int ADDR_MAX_BITS        = 24;

   // request codes
   localparam logic [1:0] CMD_SET_ADDR = 2'd0;
   localparam logic [1:0] CMD_WRITE    = 2'd1;
   localparam logic [1:0] CMD_READ     = 2'd2;
   localparam logic [1:0] CMD_FINISH   = 2'd3;

   // frame action codes
   localparam logic [1:0] ACT_SEND    = 2'd0;
   localparam logic [1:0] ACT_CAPTURE = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;
   localparam logic [1:0] ACT_WAIT    = 2'd3;

   // open transaction codes
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // EEPROM opcodes
   localparam logic [7:0] OP_WREN  = 8'h06;
   localparam logic [7:0] OP_WRITE = 8'h02;
   localparam logic [7:0] OP_READ  = 8'h03;

   localparam logic [4:0] CS_RELEASED = 5'h1f;

   // Fixed order of result slots; a plan enables a subset of them.
   localparam int SLOT_COUNT     = 11;
   localparam int SLOT_IDX_BITS  = 4;
   localparam int SLOT_CLOSE_REL = 0;
   localparam int SLOT_CLOSE_WAIT = 1;
   localparam int SLOT_WREN      = 2;
   localparam int SLOT_WREN_REL  = 3;
   localparam int SLOT_OPCODE    = 4;
   localparam int SLOT_ADDR_HI   = 5;
   localparam int SLOT_ADDR_MID  = 6;
   localparam int SLOT_ADDR_LO   = 7;
   localparam int SLOT_BODY      = 8;
   localparam int SLOT_END_REL   = 9;
   localparam int SLOT_END_WAIT  = 10;

   typedef struct packed {
      logic [SLOT_COUNT-1:0]    slots;
      logic                     is_write;
      logic [ADDR_MAX_BITS-1:0] addr;
      logic [7:0]               data;
      logic [4:0]               cs;
   } plan_type;

   // active-low select for the given index; indexes past four select nothing
   function automatic logic [4:0] cs_mask_of(input logic [2:0] idx);
      logic [4:0] m;
      m = CS_RELEASED;
      if (idx < 3'd5) begin
         m[idx] = 1'b0;
      end
      return m;
   endfunction

endpackage

>>> hw/rtl/spi_eeprom_access_sequencer_top.sv
// The first result of an item passes the queue head, the back-end plan register
// and the result register. One result per cycle unless rsp_ready stalls; an
// item has 1 to 10 results in the back-end slot walker; empty ones never queue.
// A two-entry plan queue lets the front accept while the back is still sending.
// Reset (synchronous, active high): address 0, no transaction open, select 0.
// ----------------------------------------------------------------------------
// spi_eeprom_access_sequencer_top
// EEPROM byte requests in, SPI frame actions out.
// ----------------------------------------------------------------------------
module spi_eeprom_access_sequencer_top #(
   parameter int ADDRESS_BITS = sas_pkg::ADDRESS_BITS_DEFAULT,
   parameter int PAGE_BYTES   = sas_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_cmd,
   input  logic [ADDRESS_BITS-1:0] req_address,
   input  logic [7:0]              req_data_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_action,
   output logic [7:0]              rsp_tx_byte,
   output logic [4:0]              rsp_cs_mask,
   output logic                    rsp_last,
   input  logic                    csr_wr_en,
   input  logic [2:0]              csr_wr_data
);

   logic              q_push, q_pop, q_full, q_valid;
   sas_pkg::plan_type push_plan, head_plan;

   sas_front #(
      .ADDRESS_BITS(ADDRESS_BITS),
      .PAGE_BYTES  (PAGE_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_address  (req_address),
      .req_data_byte(req_data_byte),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_plan       (push_plan)
   );

   sas_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_plan (push_plan),
      .pop       (q_pop),
      .full      (q_full),
      .head_valid(q_valid),
      .head_plan (head_plan)
   );

   sas_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_plan     (head_plan),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_action (rsp_action),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_cs_mask(rsp_cs_mask),
      .rsp_last   (rsp_last)
   );

`ifndef SYNTHESIS
   // every accepted write or read carries at least its body action
   a_body_queued: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == sas_pkg::CMD_WRITE ||
       req_cmd == sas_pkg::CMD_READ)) |-> q_push)
      else $error("accepted data request did not enter the plan queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("plan pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("plan popped from an empty queue");
`endif

endmodule

>>> hw/rtl/sas_front.sv
// ----------------------------------------------------------------------------
// sas_front
// Accepts requests, tracks address and open transaction, builds slot plans.
// ----------------------------------------------------------------------------
module sas_front #(
   parameter int ADDRESS_BITS = sas_pkg::ADDRESS_BITS_DEFAULT,
   parameter int PAGE_BYTES   = sas_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_cmd,
   input  logic [ADDRESS_BITS-1:0] req_address,
   input  logic [7:0]              req_data_byte,
   input  logic                    csr_wr_en,
   input  logic [2:0]              csr_wr_data,
   input  logic                    q_full,
   output logic                    q_push,
   output sas_pkg::plan_type       q_plan
);

   // page size is a power of two
   localparam int PageBits = $clog2(PAGE_BYTES);

   logic [ADDRESS_BITS-1:0] addr_ff, addr_in, addr_next;
   logic [1:0]              mode_ff, mode_in;
   logic [2:0]              csr_ff;
   logic                    accept, wr_open, rd_open, boundary;
   logic [sas_pkg::SLOT_COUNT-1:0] slots;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign wr_open   = (mode_ff == sas_pkg::MODE_WRITE);
   assign rd_open   = (mode_ff == sas_pkg::MODE_READ);
   assign addr_next = ADDRESS_BITS'(addr_ff + 1'b1);
   assign boundary  = (addr_next[PageBits-1:0] == '0) || (addr_next == '0);

   always_comb begin
      slots   = '0;
      addr_in = addr_ff;
      mode_in = mode_ff;
      case (req_cmd)
         sas_pkg::CMD_WRITE: begin
            if (!wr_open) begin
               slots[sas_pkg::SLOT_CLOSE_REL] = rd_open;
               slots[sas_pkg::SLOT_WREN]      = 1'b1;
               slots[sas_pkg::SLOT_WREN_REL]  = 1'b1;
               slots[sas_pkg::SLOT_OPCODE]    = 1'b1;
               slots[sas_pkg::SLOT_ADDR_HI]   = 1'b1;
               slots[sas_pkg::SLOT_ADDR_MID]  = 1'b1;
               slots[sas_pkg::SLOT_ADDR_LO]   = 1'b1;
            end
            slots[sas_pkg::SLOT_BODY]     = 1'b1;
            slots[sas_pkg::SLOT_END_REL]  = boundary;
            slots[sas_pkg::SLOT_END_WAIT] = boundary;
            addr_in = addr_next;
            mode_in = boundary ? sas_pkg::MODE_NONE : sas_pkg::MODE_WRITE;
         end
         sas_pkg::CMD_READ: begin
            if (!rd_open) begin
               slots[sas_pkg::SLOT_CLOSE_REL]  = wr_open;
               slots[sas_pkg::SLOT_CLOSE_WAIT] = wr_open;
               slots[sas_pkg::SLOT_OPCODE]     = 1'b1;
               slots[sas_pkg::SLOT_ADDR_HI]    = 1'b1;
               slots[sas_pkg::SLOT_ADDR_MID]   = 1'b1;
               slots[sas_pkg::SLOT_ADDR_LO]    = 1'b1;
            end
            slots[sas_pkg::SLOT_BODY] = 1'b1;
            addr_in = addr_next;
            mode_in = sas_pkg::MODE_READ;
         end
         sas_pkg::CMD_SET_ADDR: begin
            slots[sas_pkg::SLOT_CLOSE_REL]  = wr_open || rd_open;
            slots[sas_pkg::SLOT_CLOSE_WAIT] = wr_open;
            addr_in = req_address;
            mode_in = sas_pkg::MODE_NONE;
         end
         default: begin
            slots[sas_pkg::SLOT_CLOSE_REL]  = wr_open || rd_open;
            slots[sas_pkg::SLOT_CLOSE_WAIT] = wr_open;
            mode_in = sas_pkg::MODE_NONE;
         end
      endcase
   end

   // items with nothing to send never enter the queue
   assign q_push          = accept && (slots != '0);
   assign q_plan.slots    = slots;
   assign q_plan.is_write = (req_cmd == sas_pkg::CMD_WRITE);
   assign q_plan.addr     = sas_pkg::ADDR_MAX_BITS'(addr_ff);
   assign q_plan.data     = req_data_byte;
   assign q_plan.cs       = sas_pkg::cs_mask_of(csr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         mode_ff <= sas_pkg::MODE_NONE;
         csr_ff  <= '0;
      end else begin
         if (accept) begin
            addr_ff <= addr_in;
            mode_ff <= mode_in;
         end
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
   end

endmodule

>>> hw/rtl/sas_queue.sv
// ----------------------------------------------------------------------------
// sas_queue
// Two-entry plan queue between front and back; head entry is always slot 0.
// ----------------------------------------------------------------------------
module sas_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sas_pkg::plan_type push_plan,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output sas_pkg::plan_type head_plan
);

   logic [1:0]        count_ff, count_in;
   sas_pkg::plan_type head_ff, tail_ff;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_plan  = head_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && pop) begin
         if (count_ff == 2'd1) begin
            head_ff <= push_plan;
         end else begin
            head_ff <= tail_ff;
            tail_ff <= push_plan;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_ff <= push_plan;
         end else begin
            tail_ff <= push_plan;
         end
      end else if (pop) begin
         head_ff <= tail_ff;
      end
   end

endmodule

>>> hw/rtl/sas_back.sv
// ----------------------------------------------------------------------------
// sas_back
// Walks the enabled slots of one plan, one frame action per cycle while the
// registered result stage is free to take it.
// ----------------------------------------------------------------------------
module sas_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  sas_pkg::plan_type q_plan,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_action,
   output logic [7:0]        rsp_tx_byte,
   output logic [4:0]        rsp_cs_mask,
   output logic              rsp_last
);

   sas_pkg::plan_type                 cur_ff;
   logic [sas_pkg::SLOT_COUNT-1:0]    slots_in, rem;
   logic [sas_pkg::SLOT_IDX_BITS-1:0] idx;
   logic                              out_free, emit, load;
   logic                              valid_ff, valid_in;
   logic [1:0]                        action_ff, action_in;
   logic [7:0]                        byte_ff, byte_in;
   logic [4:0]                        cs_ff, cs_in;
   logic                              last_ff;

   // lowest enabled slot goes next
   always_comb begin
      idx = '0;
      for (int i = sas_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (cur_ff.slots[i]) begin
            idx = sas_pkg::SLOT_IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      rem      = cur_ff.slots;
      rem[idx] = 1'b0;
   end

   assign out_free = !valid_ff || rsp_ready;
   assign emit     = out_free && (cur_ff.slots != '0);
   assign load     = q_valid && ((cur_ff.slots == '0) || (emit && (rem == '0)));
   assign q_pop    = load;

   always_comb begin
      slots_in = cur_ff.slots;
      if (load) begin
         slots_in = q_plan.slots;
      end else if (emit) begin
         slots_in = rem;
      end
   end

   always_comb begin
      action_in = sas_pkg::ACT_SEND;
      byte_in   = 8'h00;
      cs_in     = cur_ff.cs;
      case (idx)
         sas_pkg::SLOT_CLOSE_REL, sas_pkg::SLOT_WREN_REL, sas_pkg::SLOT_END_REL: begin
            action_in = sas_pkg::ACT_RELEASE;
            cs_in     = sas_pkg::CS_RELEASED;
         end
         sas_pkg::SLOT_CLOSE_WAIT, sas_pkg::SLOT_END_WAIT: begin
            action_in = sas_pkg::ACT_WAIT;
            cs_in     = sas_pkg::CS_RELEASED;
         end
         sas_pkg::SLOT_WREN:     byte_in = sas_pkg::OP_WREN;
         sas_pkg::SLOT_OPCODE:   byte_in = cur_ff.is_write ? sas_pkg::OP_WRITE : sas_pkg::OP_READ;
         sas_pkg::SLOT_ADDR_HI:  byte_in = cur_ff.addr[23:16];
         sas_pkg::SLOT_ADDR_MID: byte_in = cur_ff.addr[15:8];
         sas_pkg::SLOT_ADDR_LO:  byte_in = cur_ff.addr[7:0];
         sas_pkg::SLOT_BODY: begin
            if (cur_ff.is_write) begin
               byte_in = cur_ff.data;
            end else begin
               action_in = sas_pkg::ACT_CAPTURE;
            end
         end
         default: begin
            action_in = sas_pkg::ACT_SEND;
         end
      endcase
   end

   assign valid_in = emit || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.slots <= '0;
         valid_ff     <= 1'b0;
      end else begin
         cur_ff.slots <= slots_in;
         valid_ff     <= valid_in;
      end
      if (load) begin
         cur_ff.is_write <= q_plan.is_write;
         cur_ff.addr     <= q_plan.addr;
         cur_ff.data     <= q_plan.data;
         cur_ff.cs       <= q_plan.cs;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         action_ff <= action_in;
         byte_ff   <= byte_in;
         cs_ff     <= cs_in;
         last_ff   <= (rem == '0);
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_action  = action_ff;
   assign rsp_tx_byte = byte_ff;
   assign rsp_cs_mask = cs_ff;
   assign rsp_last    = last_ff;

endmodule
